/* hw/rtl/prf_pkg.sv */
package prf_pkg;

    // Size of the response buffer downstream; the stored length saturates below it.
    localparam int BufferBytes = 256;
    localparam int LenCapInt   = (BufferBytes - 1 > 255) ? 255 : BufferBytes - 1;
    localparam logic [7:0] LEN_CAP = 8'(LenCapInt);

    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_LT    = 8'h3c;
    localparam logic [7:0] CHAR_GT    = 8'h3e;
    localparam logic [7:0] CHAR_STAR  = 8'h2a;
    localparam logic [7:0] CHAR_COLON = 8'h3a;
    localparam logic [7:0] CHAR_DOT   = 8'h2e;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [2:0] MODE_BRACKET = 3'd2;
    localparam logic [2:0] MODE_STATUS  = 3'd3;
    localparam logic [2:0] MODE_CR      = 3'd4;

    localparam logic [2:0] MODE_RESET    = MODE_CR;
    localparam logic [7:0] TIMEOUT_RESET = 8'd3;

    localparam logic [1:0] REG_MODE    = 2'd0;
    localparam logic [1:0] REG_TIMEOUT = 2'd1;

    // Bracket counter code for "no opening bracket seen yet".
    localparam logic [2:0] BR_NONE = 3'd7;
    localparam logic [2:0] BR_LAST = 3'd4;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_TICK  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_RECV = 2'd1,
        PH_DONE = 2'd2
    } t_phase;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] rx_byte;
        logic       overrun_flag;
        logic       framing_flag;
        logic       parity_flag;
    } t_item;

    typedef struct packed {
        logic       store_valid;
        logic [7:0] store_byte;
        logic       frame_done;
        logic       timed_out;
        logic       overrun_seen;
        logic       framing_seen;
        logic       parity_seen;
        logic [7:0] response_length;
        logic       overflow;
    } t_result;

    typedef struct packed {
        logic [2:0] protocol_mode;
        logic [7:0] timeout_ticks;
    } t_cfg;

endpackage

/* hw/rtl/prf_ifs.sv */
interface prf_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] rx_byte;
    logic       overrun_flag;
    logic       framing_flag;
    logic       parity_flag;

    modport source (output valid, operation, rx_byte, overrun_flag, framing_flag,
                    parity_flag, input ready);
    modport sink   (input valid, operation, rx_byte, overrun_flag, framing_flag,
                    parity_flag, output ready);
endinterface

interface prf_out_if;
    logic       valid;
    logic       ready;
    logic       store_valid;
    logic [7:0] store_byte;
    logic       frame_done;
    logic       timed_out;
    logic       overrun_seen;
    logic       framing_seen;
    logic       parity_seen;
    logic [7:0] response_length;
    logic       overflow;

    modport source (output valid, store_valid, store_byte, frame_done, timed_out,
                    overrun_seen, framing_seen, parity_seen, response_length, overflow,
                    input ready);
    modport sink   (input valid, store_valid, store_byte, frame_done, timed_out,
                    overrun_seen, framing_seen, parity_seen, response_length, overflow,
                    output ready);
endinterface

interface prf_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/prf_cfg_regs.sv */
module prf_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    prf_cfg_if.sink       i_cfg,
    output prf_pkg::t_cfg o_cfg
);
    import prf_pkg::*;

    logic [2:0] r_mode;
    logic [7:0] r_timeout;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_RESET;
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == REG_MODE) begin
                r_mode <= i_cfg.data[2:0];
            end
            if (i_cfg.index == REG_TIMEOUT) begin
                r_timeout <= i_cfg.data;
            end
        end
    end

    assign o_cfg.protocol_mode = r_mode;
    assign o_cfg.timeout_ticks = r_timeout;
endmodule

/* hw/rtl/prf_frame_core.sv */
module prf_frame_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  prf_pkg::t_item   i_item,
    input  prf_pkg::t_cfg    i_cfg,
    output prf_pkg::t_result o_res
);
    import prf_pkg::*;

    t_phase     r_phase, n_phase;
    logic [2:0] r_bracket, n_bracket;
    logic [7:0] r_ticks, n_ticks;
    logic [7:0] r_len, n_len;
    logic [2:0] r_err, n_err;
    logic       r_ovf, n_ovf;

    logic       keep, done, tout, store;
    t_op        op;
    logic [7:0] b;

    assign op = t_op'(i_item.operation);
    assign b  = i_item.rx_byte;

    // Byte filtering, counters and latches.
    always_comb begin
        n_bracket = r_bracket;
        n_ticks   = r_ticks;
        n_len     = r_len;
        n_err     = r_err;
        n_ovf     = r_ovf;
        keep      = 1'b0;
        done      = 1'b0;
        tout      = 1'b0;
        store     = 1'b0;
        unique case (op)
            OP_START: begin
                n_bracket = BR_NONE;
                n_ticks   = '0;
                n_len     = '0;
                n_err     = '0;
                n_ovf     = 1'b0;
            end
            OP_BYTE: begin
                if (r_phase == PH_RECV) begin
                    n_err = r_err | {i_item.parity_flag, i_item.framing_flag,
                                     i_item.overrun_flag};
                    if (b != 8'd0) begin
                        unique case (i_cfg.protocol_mode)
                            MODE_BRACKET: begin
                                if (b == CHAR_LT) begin
                                    if (r_bracket == BR_NONE) begin
                                        n_bracket = 3'd0;
                                        keep      = 1'b1;
                                    end
                                end else if (b == CHAR_GT) begin
                                    n_bracket = 3'd1;
                                    keep      = 1'b1;
                                end else if (!b[7]) begin
                                    keep = 1'b1;
                                    // The fourth byte after a closing bracket ends it.
                                    if (r_bracket != 3'd0 && r_bracket != BR_NONE) begin
                                        n_bracket = r_bracket + 3'd1;
                                        done      = (r_bracket == BR_LAST);
                                    end
                                end
                            end
                            MODE_STATUS: begin
                                if (b == CHAR_COLON || b == CHAR_GT || b == CHAR_LT ||
                                    b == CHAR_STAR) begin
                                    keep = 1'b1;
                                    done = 1'b1;
                                end else if ((b >= CHAR_ZERO && b <= CHAR_NINE) ||
                                             b == CHAR_DOT) begin
                                    keep = 1'b1;
                                end
                            end
                            MODE_CR: begin
                                if (b == CHAR_CR) begin
                                    keep = 1'b1;
                                    done = 1'b1;
                                end else if (b != CHAR_LF) begin
                                    keep = 1'b1;
                                end
                            end
                            default: begin
                                keep = 1'b0;
                            end
                        endcase
                        if (keep) begin
                            if (r_len < LEN_CAP) begin
                                store = 1'b1;
                                n_len = r_len + 8'd1;
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                    end
                end
            end
            OP_TICK: begin
                if (r_phase == PH_RECV) begin
                    if (r_ticks != 8'hff) begin
                        n_ticks = r_ticks + 8'd1;
                    end
                    tout = (n_ticks >= i_cfg.timeout_ticks);
                end
            end
            OP_NOP: begin
                keep = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        if (op == OP_START) begin
            n_phase = PH_RECV;
        end else if (done || tout) begin
            n_phase = PH_DONE;
        end
    end

    always_comb begin
        o_res.store_valid     = store;
        o_res.store_byte      = store ? b : 8'd0;
        o_res.frame_done      = done;
        o_res.timed_out       = tout;
        o_res.overrun_seen    = n_err[0];
        o_res.framing_seen    = n_err[1];
        o_res.parity_seen     = n_err[2];
        o_res.response_length = n_len;
        o_res.overflow        = n_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_bracket <= BR_NONE;
            r_ticks   <= '0;
            r_len     <= '0;
            r_err     <= '0;
            r_ovf     <= 1'b0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_bracket <= n_bracket;
            r_ticks   <= n_ticks;
            r_len     <= n_len;
            r_err     <= n_err;
            r_ovf     <= n_ovf;
        end
    end
endmodule

/* hw/rtl/pump_response_framer_top.sv */
// Pump response framer.
// i_in carries one beat per event: start of an exchange, a received byte with its
// line status flags, or a timer tick. o_out returns exactly one result beat per input
// beat, in order: whether the byte was stored, end of frame, timeout, the error and
// overflow latches of the exchange and the stored length.
// i_cfg writes the protocol mode (index 0) and the timeout in ticks (index 1); it is
// always ready and should only be used while no beats are in flight.
// An accepted beat waits in the input register until it fires; the framing logic then
// updates its state and loads the result register, which presents the result beat
// until the receiver takes it.
// One beat is accepted every cycle while the receiver keeps taking results; the framing
// core updates its state once per beat.
// Reset puts the framer in the idle phase with all latches and counters clear, mode 4
// and a timeout of 3 ticks. In idle, bytes and ticks pass through without effect.
// When the receiver stalls, the result register holds and the input register fills;
// i_in.ready then drops until the result is taken.
module pump_response_framer_top (
    input  logic     i_clk,
    input  logic     i_rst_n,
    prf_in_if.sink   i_in,
    prf_out_if.source o_out,
    prf_cfg_if.sink  i_cfg
);
    import prf_pkg::*;

    t_cfg    cfg;
    t_result res;
    t_item   n_item;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_res_valid;
    t_result r_res;
    logic    advance, fire, accept;

    prf_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    prf_frame_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    assign advance    = !r_res_valid || o_out.ready;
    assign fire       = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;
    assign accept     = i_in.valid && i_in.ready;

    assign n_item = '{operation:    i_in.operation,
                      rx_byte:      i_in.rx_byte,
                      overrun_flag: i_in.overrun_flag,
                      framing_flag: i_in.framing_flag,
                      parity_flag:  i_in.parity_flag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_res_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= n_item;
        end
        if (fire) begin
            r_res <= res;
        end
    end

    assign o_out.valid           = r_res_valid;
    assign o_out.store_valid     = r_res.store_valid;
    assign o_out.store_byte      = r_res.store_byte;
    assign o_out.frame_done      = r_res.frame_done;
    assign o_out.timed_out       = r_res.timed_out;
    assign o_out.overrun_seen    = r_res.overrun_seen;
    assign o_out.framing_seen    = r_res.framing_seen;
    assign o_out.parity_seen     = r_res.parity_seen;
    assign o_out.response_length = r_res.response_length;
    assign o_out.overflow        = r_res.overflow;

`ifndef SYNTHESIS
    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.response_length <= LEN_CAP)
        else $error("stored length above buffer capacity");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.overflow) |-> o_out.response_length == LEN_CAP)
        else $error("overflow reported with buffer not full");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_in_valid && r_res_valid && !o_out.ready))
        else $error("input stalled without a full pipeline");

    a_fire_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_res_valid)
        else $error("processed beat did not reach the result register");
`endif
endmodule

/* verif/pump_response_framer_top_tb.sv */
module pump_response_framer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import prf_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    // Indexes that decode to no register; writes to them must change nothing.
    localparam logic [1:0] REG_SPARE_A = 2'd2;
    localparam logic [1:0] REG_SPARE_B = 2'd3;

    class frame_status_tracker;
        logic [2:0] mode;
        logic [7:0] timeout;
        t_phase     ph;
        logic [2:0] arm;
        logic [7:0] ticks;
        logic [7:0] stored_cnt;
        logic       ovr_l, frm_l, par_l;
        logic       ovf_l;
        t_result    expected_status[$];
        int         errors;
        int         noted;
        int         checked;
        int         frames_done;
        int         timeouts;
        int         cfg_writes;

        function new();
            mode = MODE_RESET;
            timeout = TIMEOUT_RESET;
            ph = PH_IDLE;
            clear_exchange();
        endfunction

        function void clear_exchange();
            arm = BR_NONE;
            ticks = 8'd0;
            stored_cnt = 8'd0;
            ovr_l = 1'b0;
            frm_l = 1'b0;
            par_l = 1'b0;
            ovf_l = 1'b0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [7:0] data);
            cfg_writes++;
            if (idx == REG_MODE) begin
                mode = data[2:0];
            end else if (idx == REG_TIMEOUT) begin
                timeout = data;
            end
        endfunction

        function int outstanding();
            return expected_status.size();
        endfunction

        function void note_beat(t_item it);
            t_result    r;
            logic       keep, stored, done, tout;
            logic [7:0] b;
            b = it.rx_byte;
            keep = 1'b0;
            stored = 1'b0;
            done = 1'b0;
            tout = 1'b0;
            noted++;
            case (it.operation)
                OP_START: begin
                    clear_exchange();
                    ph = PH_RECV;
                end
                OP_BYTE: begin
                    if (ph == PH_RECV) begin
                        ovr_l |= it.overrun_flag;
                        frm_l |= it.framing_flag;
                        par_l |= it.parity_flag;
                        if (b != 8'h00) begin
                            case (mode)
                                MODE_BRACKET: begin
                                    if (b == CHAR_LT) begin
                                        // Only the first opening bracket is kept.
                                        if (arm == BR_NONE) begin
                                            arm = 3'd0;
                                            keep = 1'b1;
                                        end
                                    end else if (b == CHAR_GT) begin
                                        arm = 3'd1;
                                        keep = 1'b1;
                                    end else if (!b[7]) begin
                                        keep = 1'b1;
                                        if (arm != BR_NONE && arm != 3'd0) arm = arm + 3'd1;
                                        if (arm != BR_NONE && arm > BR_LAST) done = 1'b1;
                                    end
                                end
                                MODE_STATUS: begin
                                    if (b == CHAR_COLON || b == CHAR_GT || b == CHAR_LT ||
                                        b == CHAR_STAR) begin
                                        keep = 1'b1;
                                        done = 1'b1;
                                    end else if ((b >= CHAR_ZERO && b <= CHAR_NINE) ||
                                                 b == CHAR_DOT) begin
                                        keep = 1'b1;
                                    end
                                end
                                MODE_CR: begin
                                    if (b == CHAR_CR) begin
                                        keep = 1'b1;
                                        done = 1'b1;
                                    end else if (b != CHAR_LF) begin
                                        keep = 1'b1;
                                    end
                                end
                                default: ;
                            endcase
                            if (keep) begin
                                if (stored_cnt < LEN_CAP) begin
                                    stored_cnt = stored_cnt + 8'd1;
                                    stored = 1'b1;
                                end else begin
                                    ovf_l = 1'b1;
                                end
                            end
                            if (done) ph = PH_DONE;
                        end
                    end
                end
                OP_TICK: begin
                    if (ph == PH_RECV) begin
                        if (ticks != 8'hff) ticks = ticks + 8'd1;
                        if (ticks >= timeout) begin
                            tout = 1'b1;
                            ph = PH_DONE;
                        end
                    end
                end
                default: ;
            endcase
            if (done) frames_done++;
            if (tout) timeouts++;
            r.store_valid = stored;
            r.store_byte = stored ? b : 8'h00;
            r.frame_done = done;
            r.timed_out = tout;
            r.overrun_seen = ovr_l;
            r.framing_seen = frm_l;
            r.parity_seen = par_l;
            r.response_length = stored_cnt;
            r.overflow = ovf_l;
            expected_status.push_back(r);
        endfunction

        function void cmp(string name, logic [7:0] e, logic [7:0] a);
            if (e !== a) begin
                $error("%s: expected %0h, got %0h", name, e, a);
                errors++;
            end
        endfunction

        function void check_beat(t_result got);
            t_result e;
            if (expected_status.size() == 0) begin
                $error("result beat arrived with no input beat outstanding");
                errors++;
                return;
            end
            e = expected_status.pop_front();
            checked++;
            cmp("store_valid", 8'(e.store_valid), 8'(got.store_valid));
            cmp("store_byte", e.store_byte, got.store_byte);
            cmp("frame_done", 8'(e.frame_done), 8'(got.frame_done));
            cmp("timed_out", 8'(e.timed_out), 8'(got.timed_out));
            cmp("overrun_seen", 8'(e.overrun_seen), 8'(got.overrun_seen));
            cmp("framing_seen", 8'(e.framing_seen), 8'(got.framing_seen));
            cmp("parity_seen", 8'(e.parity_seen), 8'(got.parity_seen));
            cmp("response_length", e.response_length, got.response_length);
            cmp("overflow", 8'(e.overflow), 8'(got.overflow));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    prf_in_if  in_bus();
    prf_out_if res_bus();
    prf_cfg_if cfg_bus();

    pump_response_framer_top i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_bus),
        .o_out  (res_bus),
        .i_cfg  (cfg_bus)
    );

    frame_status_tracker tracker = new();

    t_result seen_status;
    int      cycles;
    int      burst_left;
    bit      steady;
    bit      hold_req;
    int      hold_left;
    int      stall_style;
    int      stall_left;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("pump_response_framer_top verification failed");
        $finish;
    end

    // Receiver: picks a new random stall style whenever the current one runs out, and on request
    // holds off for a long stretch so that the block backs up into its input.
    initial begin
        res_bus.ready = 1'b0;
        hold_left = 0;
        stall_left = 0;
        stall_style = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                res_bus.ready = 1'b0;
                hold_left--;
            end else begin
                if (stall_left == 0) begin
                    stall_style = $urandom_range(0, 3);
                    stall_left = $urandom_range(20, 80);
                end
                stall_left--;
                case (stall_style)
                    0: res_bus.ready = 1'b1;
                    1: res_bus.ready = 1'($urandom_range(0, 1));
                    2: res_bus.ready = ($urandom_range(0, 3) == 0);
                    default: res_bus.ready = ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            seen_status.store_valid = res_bus.store_valid;
            seen_status.store_byte = res_bus.store_byte;
            seen_status.frame_done = res_bus.frame_done;
            seen_status.timed_out = res_bus.timed_out;
            seen_status.overrun_seen = res_bus.overrun_seen;
            seen_status.framing_seen = res_bus.framing_seen;
            seen_status.parity_seen = res_bus.parity_seen;
            seen_status.response_length = res_bus.response_length;
            seen_status.overflow = res_bus.overflow;
            tracker.check_beat(seen_status);
        end
    end

    task automatic push_beat(t_item it);
        @(negedge i_clk);
        in_bus.operation = it.operation;
        in_bus.rx_byte = it.rx_byte;
        in_bus.overrun_flag = it.overrun_flag;
        in_bus.framing_flag = it.framing_flag;
        in_bus.parity_flag = it.parity_flag;
        in_bus.valid = 1'b1;
        do @(posedge i_clk); while (!in_bus.ready);
        tracker.note_beat(it);
    endtask

    task automatic idle_input(int n);
        repeat (n) begin
            @(negedge i_clk);
            in_bus.valid = 1'b0;
        end
    endtask

    task automatic offer(t_item it);
        if (!steady && burst_left == 0) begin
            idle_input($urandom_range(1, 6));
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0) burst_left--;
        push_beat(it);
    endtask

    task automatic send_flagged(logic [7:0] b, logic ovr, logic frm, logic par);
        t_item it;
        it.operation = OP_BYTE;
        it.rx_byte = b;
        it.overrun_flag = ovr;
        it.framing_flag = frm;
        it.parity_flag = par;
        offer(it);
    endtask

    task automatic send_byte(logic [7:0] b);
        send_flagged(b, $urandom_range(0, 11) == 0, $urandom_range(0, 11) == 0,
                     $urandom_range(0, 11) == 0);
    endtask

    // Control beats carry random payload; the block must not look at it.
    task automatic send_ctl(t_op op);
        t_item it;
        it.operation = op;
        it.rx_byte = 8'($urandom_range(0, 255));
        it.overrun_flag = 1'($urandom_range(0, 1));
        it.framing_flag = 1'($urandom_range(0, 1));
        it.parity_flag = 1'($urandom_range(0, 1));
        offer(it);
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_bus.valid = 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] data);
        while (tracker.outstanding() != 0) @(posedge i_clk);
        @(negedge i_clk);
        cfg_bus.index = idx;
        cfg_bus.data = data;
        cfg_bus.valid = 1'b1;
        do @(posedge i_clk); while (!cfg_bus.ready);
        tracker.set_reg(idx, data);
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
    endtask

    function automatic logic [7:0] body_byte(logic [2:0] m);
        logic [7:0] b;
        int         r;
        r = $urandom_range(0, 19);
        case (m)
            MODE_BRACKET: begin
                b = 8'($urandom_range(8'h20, 8'h7e));
                if (b == CHAR_GT) b = CHAR_DOT;
            end
            MODE_STATUS: begin
                if (r < 3) b = CHAR_DOT;
                else if (r < 15) b = CHAR_ZERO + 8'($urandom_range(0, 9));
                else b = 8'($urandom_range(8'h20, 8'h7e));
            end
            MODE_CR: begin
                if (r < 2) b = CHAR_LF;
                else if (r == 2) b = 8'($urandom_range(0, 255));
                else b = 8'($urandom_range(8'h20, 8'h7e));
            end
            default: b = 8'($urandom_range(1, 255));
        endcase
        return b;
    endfunction

    function automatic logic [7:0] status_char();
        case ($urandom_range(0, 3))
            0: return CHAR_COLON;
            1: return CHAR_GT;
            2: return CHAR_LT;
            default: return CHAR_STAR;
        endcase
    endfunction

    // One exchange: mostly a well-formed reply for the current mode with random
    // content, salted with noise, ticks, restarts and missing terminators.
    task automatic run_exchange();
        logic [2:0] m;
        int         len;
        int         k;
        m = tracker.mode;
        if ($urandom_range(0, 9) != 0) send_ctl(OP_START);
        if (m == MODE_BRACKET && $urandom_range(0, 4) != 0) send_byte(CHAR_LT);
        len = $urandom_range(0, 10);
        for (k = 0; k < len; k++) begin
            case ($urandom_range(0, 49))
                0, 1, 2: send_byte(8'($urandom_range(0, 255)));
                3:       send_byte(8'h00);
                4, 5:    send_ctl(OP_TICK);
                6:       send_ctl(OP_NOP);
                7:       send_ctl(OP_START);
                default: send_byte(body_byte(m));
            endcase
        end
        if ($urandom_range(0, 7) != 0) begin
            case (m)
                MODE_BRACKET: begin
                    send_byte(CHAR_GT);
                    repeat (4) send_byte(body_byte(m));
                end
                MODE_STATUS: send_byte(status_char());
                MODE_CR:     send_byte(CHAR_CR);
                default:     send_byte(8'($urandom_range(0, 255)));
            endcase
        end
        repeat ($urandom_range(0, 2)) begin
            if ($urandom_range(0, 1) != 0) send_byte(8'($urandom_range(0, 255)));
            else send_ctl(OP_TICK);
        end
    endtask

    task automatic run_phase(logic [2:0] m, logic [7:0] tmo, int n, bit no_gaps);
        int first;
        write_reg(REG_MODE, {5'($urandom), m});
        write_reg(REG_TIMEOUT, tmo);
        steady = no_gaps;
        first = tracker.noted;
        while (tracker.noted - first < n) run_exchange();
        drain();
    endtask

    initial begin
        logic [7:0] b;
        i_rst_n = 1'b0;
        in_bus.valid = 1'b0;
        in_bus.operation = OP_NOP;
        in_bus.rx_byte = 8'h00;
        in_bus.overrun_flag = 1'b0;
        in_bus.framing_flag = 1'b0;
        in_bus.parity_flag = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = REG_MODE;
        cfg_bus.data = 8'h00;
        hold_req = 1'b0;
        steady = 1'b0;
        burst_left = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: carriage-return mode, three-tick timeout.
        send_flagged("A", 1'b1, 1'b1, 1'b1);
        send_ctl(OP_TICK);
        send_ctl(OP_NOP);
        send_ctl(OP_START);
        send_flagged(8'h00, 1'b1, 1'b0, 1'b0);
        send_flagged(CHAR_LF, 1'b0, 1'b1, 1'b0);
        send_flagged(8'hff, 1'b0, 1'b0, 1'b1);
        send_flagged(8'h01, 1'b0, 1'b0, 1'b0);
        send_ctl(OP_NOP);
        send_flagged(CHAR_CR, 1'b0, 1'b0, 1'b0);
        send_flagged("B", 1'b1, 1'b0, 1'b0);
        send_ctl(OP_TICK);
        send_ctl(OP_START);
        repeat (3) send_ctl(OP_TICK);
        send_flagged("C", 1'b0, 1'b0, 1'b0);
        drain();

        // Bracket framing: duplicate opener, non-ASCII, re-armed closer.
        write_reg(REG_MODE, MODE_BRACKET);
        write_reg(REG_TIMEOUT, 8'd255);
        send_ctl(OP_START);
        send_flagged(CHAR_LT, 1'b0, 1'b0, 1'b0);
        send_flagged(CHAR_LT, 1'b0, 1'b0, 1'b0);
        send_flagged(8'h80, 1'b0, 1'b0, 1'b0);
        send_flagged(CHAR_GT, 1'b0, 1'b0, 1'b0);
        send_flagged("x", 1'b0, 1'b0, 1'b0);
        send_flagged(CHAR_GT, 1'b0, 1'b0, 1'b0);
        send_flagged("1", 1'b0, 1'b0, 1'b0);
        send_flagged("2", 1'b0, 1'b0, 1'b0);
        send_flagged("3", 1'b0, 1'b0, 1'b0);
        send_flagged("4", 1'b0, 1'b0, 1'b0);
        drain();

        write_reg(REG_SPARE_A, 8'($urandom_range(0, 255)));
        write_reg(REG_SPARE_B, 8'($urandom_range(0, 255)));

        run_phase(MODE_STATUS, 8'd1, 30, 1'b0);
        run_phase(MODE_STATUS, 8'd255, 30, 1'b0);
        run_phase(MODE_BRACKET, 8'($urandom_range(2, 20)), 30, 1'b0);
        hold_req = 1'b1;
        run_phase(MODE_CR, 8'($urandom_range(3, 10)), 30, 1'b1);
        run_phase(3'd7, 8'($urandom_range(1, 255)), 15, 1'b0);
        case ($urandom_range(0, 3))
            0: b = 8'd0;
            1: b = 8'd1;
            2: b = 8'd5;
            default: b = 8'd6;
        endcase
        run_phase(b[2:0], 8'($urandom_range(1, 8)), 15, 1'b0);
        run_phase(MODE_BRACKET, 8'd0, 25, 1'b0);

        // Long exchanges: fill the length counter past its cap, then run the
        // tick counter up to the largest timeout.
        write_reg(REG_MODE, MODE_CR);
        write_reg(REG_TIMEOUT, 8'd255);
        steady = 1'b0;
        send_ctl(OP_START);
        repeat (262) begin
            b = 8'($urandom_range(1, 255));
            if (b == CHAR_CR || b == CHAR_LF) b = "A";
            send_byte(b);
        end
        send_byte(CHAR_CR);
        send_ctl(OP_START);
        repeat (256) send_ctl(OP_TICK);
        drain();

        run_phase(3'($urandom_range(2, 4)), 8'($urandom_range(1, 255)), 25, 1'b0);
        run_phase(MODE_BRACKET, 8'd255, 25, 1'b0);
        run_phase(MODE_CR, 8'($urandom_range(1, 255)), 25, 1'b0);

        drain();
        repeat (8) @(posedge i_clk);
        if (tracker.outstanding() != 0) begin
            $error("%0d expected result beats never arrived", tracker.outstanding());
            tracker.errors++;
        end

        $display("Run covered %0d input beats and %0d checked results over %0d cycles.",
                 tracker.noted, tracker.checked, cycles);
        $display("Frames ended: %0d, timeouts: %0d, register writes: %0d.",
                 tracker.frames_done, tracker.timeouts, tracker.cfg_writes);
        if (tracker.errors == 0) begin
            $display("pump_response_framer_top verification clean");
        end else begin
            $display("pump_response_framer_top verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/prf_pkg.sv
hw/rtl/prf_ifs.sv
hw/rtl/prf_cfg_regs.sv
hw/rtl/prf_frame_core.sv
hw/rtl/pump_response_framer_top.sv
verif/pump_response_framer_top_tb.sv
